/* rtl/core/lfsia_pkg.sv */
`timescale 1ns / 1ps

package lfsia_pkg;

    // Sizes
    localparam int SLOT_COUNT    = 16;
    localparam int TIME_BITS     = 32;
    localparam int COUNT_BITS    = 20;
    localparam int SLOT_IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SLOT_NUM_BITS = 5;
    localparam int CMD_BITS      = 2;
    localparam int LIMIT_BITS    = 5;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Input item commands
    localparam logic [CMD_BITS-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY   = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd2;

    // Register map
    localparam int REG_SLOTS_IN_USE   = 0;
    localparam int APB_ADDR_BITS      = 2;
    localparam logic [LIMIT_BITS-1:0] SLOTS_IN_USE_RESET = 5'd16;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic do_request;
        logic do_clear;
        logic acc_step;
        logic out_load;
    } lfsia_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic                query_done;
    } lfsia_stat_t;

endpackage

/* rtl/core/lowest_free_slot_interval_allocator.sv */
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: command, start_time, end_time, query_slot
// m_        out  m_tvalid/m_tready  m_tdata: granted, slot_number, prefix_count
// apb       in   psel/penable       slots_in_use at byte address 0
//
// One item at a time. Request, clear and unused commands go from the exec state to the
// done state, which holds until the output is free; a query passes the query state
// between, where the single accumulator walks the grant counts one slot per cycle.
// The next item is accepted while the previous result still waits on m_tready.
// Reset (aresetn low, synchronous) frees all slots, zeroes counts, sets
// slots_in_use to 16.

module lowest_free_slot_interval_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] command, [33:2] start_time, [65:34] end_time, [70:66] query_slot
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] granted, [5:1] slot_number, [25:6] prefix_count
    output logic [31:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lfsia_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lfsia_pkg::LIMIT_BITS-1:0]    slots_reg;
    lfsia_pkg::lfsia_cmd_t                cmd;
    lfsia_pkg::lfsia_stat_t               stat;
    logic                                out_granted;
    logic [lfsia_pkg::SLOT_NUM_BITS-1:0] out_slot_number;
    logic [lfsia_pkg::COUNT_BITS-1:0]    out_prefix_count;
    logic                                reg_sel;

    // Single register: every address in the window maps to it
    assign reg_sel = ((paddr >> 2) == lfsia_pkg::APB_ADDR_BITS'(lfsia_pkg::REG_SLOTS_IN_USE));
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? {27'd0, slots_reg} : 32'd0;

    // Configuration write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_reg <= lfsia_pkg::SLOTS_IN_USE_RESET;
        end else if (psel && penable && pwrite && reg_sel) begin
            slots_reg <= pwdata[lfsia_pkg::LIMIT_BITS-1:0];
        end
    end

    lfsia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lfsia_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .slots_in_use     (slots_reg),
        .in_command       (s_tdata[1:0]),
        .in_start_time    (s_tdata[33:2]),
        .in_end_time      (s_tdata[65:34]),
        .in_query_slot    (s_tdata[70:66]),
        .out_granted      (out_granted),
        .out_slot_number  (out_slot_number),
        .out_prefix_count (out_prefix_count)
    );

    assign m_tdata = {6'd0, out_prefix_count, out_slot_number, out_granted};

endmodule

/* rtl/core/lfsia_ctrl.sv */
`timescale 1ns / 1ps

module lfsia_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  lfsia_pkg::lfsia_stat_t stat,
    output lfsia_pkg::lfsia_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QUERY,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Command decode per state
    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_tvalid;
        cmd.do_request = (state_reg == ST_EXEC) && (stat.cmd == lfsia_pkg::CMD_REQUEST);
        cmd.do_clear   = (state_reg == ST_EXEC) && (stat.cmd == lfsia_pkg::CMD_CLEAR);
        cmd.acc_step   = (state_reg == ST_QUERY) && !stat.query_done;
        cmd.out_load   = (state_reg == ST_DONE) && out_free;
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            // New result takes priority over the one just taken
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (stat.cmd == lfsia_pkg::CMD_QUERY) begin
                        state_reg <= ST_QUERY;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_QUERY: begin
                    if (stat.query_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // One result per accepted item: a result is only loaded from the done state
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    // Input is never taken while an item is in flight
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input ready while busy");

    // A waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("result overwritten before taken");

endmodule

/* rtl/core/lfsia_dpath.sv */
`timescale 1ns / 1ps

module lfsia_dpath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  lfsia_pkg::lfsia_cmd_t                 cmd,
    output lfsia_pkg::lfsia_stat_t                stat,
    input  logic [lfsia_pkg::LIMIT_BITS-1:0]     slots_in_use,
    input  logic [lfsia_pkg::CMD_BITS-1:0]       in_command,
    input  logic [lfsia_pkg::TIME_BITS-1:0]      in_start_time,
    input  logic [lfsia_pkg::TIME_BITS-1:0]      in_end_time,
    input  logic [lfsia_pkg::SLOT_NUM_BITS-1:0]  in_query_slot,
    output logic                                 out_granted,
    output logic [lfsia_pkg::SLOT_NUM_BITS-1:0]  out_slot_number,
    output logic [lfsia_pkg::COUNT_BITS-1:0]     out_prefix_count
);

    localparam int N  = lfsia_pkg::SLOT_COUNT;
    localparam int TB = lfsia_pkg::TIME_BITS;
    localparam int CB = lfsia_pkg::COUNT_BITS;
    localparam int IB = lfsia_pkg::SLOT_IDX_BITS;
    localparam int NB = lfsia_pkg::SLOT_NUM_BITS;

    // Captured item
    logic [lfsia_pkg::CMD_BITS-1:0] cmd_reg;
    logic [TB-1:0]                  start_reg;
    logic [TB-1:0]                  end_reg;
    logic [NB-1:0]                  qk_reg;

    // Slot state
    logic [N-1:0]  busy_reg;
    logic [TB-1:0] end_time_reg [N];
    logic [CB-1:0] count_reg    [N];

    // Query walk and result holding
    logic [NB-1:0] idx_reg;
    logic [CB-1:0] acc_reg;
    logic          res_granted_reg;
    logic [NB-1:0] res_slot_reg;

    // Output register
    logic          out_granted_reg;
    logic [NB-1:0] out_slot_reg;
    logic [CB-1:0] out_prefix_reg;

    logic [N-1:0]  expire_vec;
    logic [N-1:0]  elig_vec;
    logic [N-1:0]  pick_vec;
    logic [IB-1:0] pick_idx;
    logic [CB:0]   acc_sum;

    // Release compare and eligibility per lane
    always_comb begin
        for (int i = 0; i < N; i++) begin
            expire_vec[i] = busy_reg[i] && (end_time_reg[i] < start_reg);
            elig_vec[i]   = (!busy_reg[i] || expire_vec[i]) && (i < int'(slots_in_use));
        end
    end

    // Lowest eligible lane
    assign pick_vec = elig_vec & (~elig_vec + N'(1));

    always_comb begin
        pick_idx = '0;
        for (int i = 0; i < N; i++) begin
            if (pick_vec[i]) begin
                pick_idx = pick_idx | IB'(i);
            end
        end
    end

    // Saturating accumulate of one count per step
    assign acc_sum = {1'b0, acc_reg} + {1'b0, count_reg[idx_reg[IB-1:0]]};

    assign stat.cmd        = cmd_reg;
    assign stat.query_done = (idx_reg == qk_reg) || (idx_reg == NB'(N));

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_command;
            start_reg <= in_start_time;
            end_reg   <= in_end_time;
            qk_reg    <= in_query_slot;
        end
    end

    // Slot busy and grant counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
            for (int i = 0; i < N; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.do_clear) begin
            busy_reg <= '0;
            for (int i = 0; i < N; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cmd.do_request) begin
            busy_reg <= (busy_reg & ~expire_vec) | pick_vec;
            for (int i = 0; i < N; i++) begin
                if (pick_vec[i] && (count_reg[i] != lfsia_pkg::COUNT_MAX)) begin
                    count_reg[i] <= count_reg[i] + CB'(1);
                end
            end
        end
    end

    // End times, only meaningful while busy
    always_ff @(posedge aclk) begin
        if (cmd.do_request) begin
            for (int i = 0; i < N; i++) begin
                if (pick_vec[i]) begin
                    end_time_reg[i] <= end_reg;
                end
            end
        end
    end

    // Per-item result and query walk
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg         <= '0;
            acc_reg         <= '0;
            res_granted_reg <= 1'b0;
            res_slot_reg    <= '0;
        end else begin
            if (cmd.do_request && (elig_vec != '0)) begin
                res_granted_reg <= 1'b1;
                res_slot_reg    <= NB'(pick_idx) + NB'(1);
            end
            if (cmd.acc_step) begin
                acc_reg <= acc_sum[CB] ? lfsia_pkg::COUNT_MAX : acc_sum[CB-1:0];
                idx_reg <= idx_reg + NB'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_granted_reg <= res_granted_reg;
            out_slot_reg    <= res_slot_reg;
            out_prefix_reg  <= acc_reg;
        end
    end

    assign out_granted      = out_granted_reg;
    assign out_slot_number  = out_slot_reg;
    assign out_prefix_count = out_prefix_reg;

    a_pick_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pick_vec))
        else $error("more than one slot picked");

    a_grant_sets_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.do_request && (elig_vec != '0)) |=> (res_granted_reg && (res_slot_reg != '0)))
        else $error("grant without slot number");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_clear |=> (busy_reg == '0))
        else $error("slots busy after clear");

    a_acc_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc_step && (acc_reg == lfsia_pkg::COUNT_MAX)) |=>
            (acc_reg == lfsia_pkg::COUNT_MAX))
        else $error("prefix sum left saturation");

endmodule
